@@ rtl/core/pctk_pkg.sv @@
// Package for the per-class top-K table: sizes, operation codes and the ranking compare.
// No dependencies; imported by per_class_top_k_table and its testbench.
`default_nettype none
package pctk_pkg;

    localparam int MAX_ENTRIES = 10;
    localparam int NUM_CLASSES = 4;
    localparam int RAM_DEPTH   = NUM_CLASSES * MAX_ENTRIES;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int IDX_W       = 4;
    localparam int SCORE_W     = 32;
    localparam int TAG_W       = 16;
    localparam int ENTRY_W     = SCORE_W + TAG_W;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_READOUT = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    function automatic logic ranks_above(input logic hib, input logic signed [SCORE_W-1:0] a,
                                         input logic signed [SCORE_W-1:0] b);
        ranks_above = hib ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pctk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pctk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/per_class_top_k_table.sv @@
// Per-class top-K table: top level with sequencer, class counters and output register.
// Depends on pctk_pkg and pctk_ram.
`default_nettype none
// Keeps a best-first list of up to MAX_ENTRIES (value, tag) pairs per class in one
// shared RAM. Insert and query walk the class list from its best end, one entry per
// cycle, until the value beats an entry; an insert then moves the entries below it down
// one slot per cycle; a full list drops a value that beats none of its entries. A
// readout gives one result per cycle while the output is not stalled, reading the list
// through the single RAM read port.
// Input is taken only while the sequencer is idle; results leave through an output
// register, so a new item may be taken while the last result still waits.
module per_class_top_k_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // category[1:0], score_value[33:2], entry_tag[49:34]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // qualifies[0], position[4:1], entry_count[8:5],
                                        // out_score[40:9], out_tag[56:41]
    output logic             m_tuser,   // holds_entry[0]
    output logic             m_tlast,   // last_item
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata  // higher_is_better
);
    import pctk_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SHIFT   = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_PLACE   = 3'd3;
    localparam logic [2:0] ST_RES     = 3'd4;
    localparam logic [2:0] ST_RDOUT   = 3'd5;

    localparam idx_t MAX_IDX = IDX_W'(MAX_ENTRIES);

    logic [2:0]               state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [1:0]               cls_reg, cls_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic signed [SCORE_W-1:0] val_reg, val_next;
    logic [TAG_W-1:0]         tag_reg, tag_next;
    idx_t                     idx_reg, idx_next;
    idx_t                     cnt_reg, cnt_next;
    logic [ENTRY_W-1:0]       carry_reg, carry_next;
    logic                     hib_reg, hib_next;
    idx_t                     counts_reg [NUM_CLASSES];
    idx_t                     counts_next [NUM_CLASSES];
    logic                     res_q_reg, res_q_next;
    idx_t                     res_pos_reg, res_pos_next;
    idx_t                     res_cnt_reg, res_cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [63:0]              m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;
    logic                     m_tlast_reg, m_tlast_next;

    logic [1:0]               in_op;
    logic [1:0]               in_cls;
    logic signed [SCORE_W-1:0] in_val;
    logic [TAG_W-1:0]         in_tag;
    idx_t                     in_cnt;
    logic [ADDR_W-1:0]        in_base;
    logic                     in_cls_ok;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic signed [SCORE_W-1:0] rd_val;
    logic [TAG_W-1:0]         rd_tag;
    logic                     out_free;
    logic                     above;
    logic                     rd_last;
    idx_t                     new_cnt;
    idx_t                     top_idx;

    pctk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_op     = s_tuser;
    assign in_cls    = s_tdata[1:0];
    assign in_val    = s_tdata[33:2];
    assign in_tag    = s_tdata[49:34];
    assign in_cls_ok = (32'(in_cls) < NUM_CLASSES);
    assign in_cnt    = counts_reg[in_cls];
    assign in_base   = ADDR_W'(32'(in_cls) * MAX_ENTRIES);

    assign rd_val   = ram_rdata[SCORE_W-1:0];
    assign rd_tag   = ram_rdata[ENTRY_W-1:SCORE_W];
    assign above    = ranks_above(hib_reg, val_reg, rd_val);
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_last  = (idx_reg + 1'b1 == cnt_reg);
    assign new_cnt  = (cnt_reg < MAX_IDX) ? cnt_reg + 1'b1 : cnt_reg;
    // last slot that an insert shifts into
    assign top_idx  = (cnt_reg < MAX_IDX) ? cnt_reg : MAX_IDX - 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cls_next      = cls_reg;
        base_next     = base_reg;
        val_next      = val_reg;
        tag_next      = tag_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        carry_next    = carry_reg;
        hib_next      = cfg_we ? cfg_wdata : hib_reg;
        counts_next   = counts_reg;
        res_q_next    = res_q_reg;
        res_pos_next  = res_pos_reg;
        res_cnt_next  = res_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ram_we        = 1'b0;
        ram_waddr     = base_reg + ADDR_W'(idx_reg);
        ram_wdata     = {tag_reg, val_reg};
        ram_raddr     = base_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = in_base;
                if (s_tvalid)
                begin
                    op_next      = in_op;
                    cls_next     = in_cls;
                    base_next    = in_base;
                    val_next     = in_val;
                    tag_next     = in_tag;
                    cnt_next     = in_cnt;
                    idx_next     = '0;
                    res_q_next   = 1'b0;
                    res_pos_next = '0;
                    res_cnt_next = '0;
                    if (!in_cls_ok)
                    begin
                        state_next = ST_RES;
                    end
                    else
                    begin
                        case (in_op) inside
                            OP_INSERT, OP_QUERY:
                            begin
                                state_next = (in_cnt == '0) ? ST_PLACE : ST_SCAN;
                            end
                            OP_READOUT:
                            begin
                                state_next = (in_cnt == '0) ? ST_RES : ST_RDOUT;
                            end
                            default:
                            begin
                                res_cnt_next = in_cnt;
                                state_next   = ST_RES;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr = base_reg + ADDR_W'(idx_reg) + 1'b1;
                if (above)
                begin
                    res_q_next   = 1'b1;
                    res_pos_next = idx_reg;
                    res_cnt_next = cnt_reg;
                    state_next   = ST_RES;
                    if (op_reg == OP_INSERT)
                    begin
                        ram_we               = 1'b1;
                        carry_next           = ram_rdata;
                        res_cnt_next         = new_cnt;
                        counts_next[cls_reg] = new_cnt;
                        if (idx_reg != top_idx)
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rd_last)
                    begin
                        if (cnt_reg == MAX_IDX)
                        begin
                            res_q_next   = 1'b0;
                            res_pos_next = MAX_IDX;
                            res_cnt_next = cnt_reg;
                            state_next   = ST_RES;
                        end
                        else
                        begin
                            state_next = ST_PLACE;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                ram_we     = 1'b1;
                ram_wdata  = carry_reg;
                carry_next = ram_rdata;
                if (idx_reg == top_idx)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    ram_raddr = base_reg + ADDR_W'(idx_reg) + 1'b1;
                end
            end
            ST_PLACE:
            begin
                res_q_next   = 1'b1;
                res_pos_next = idx_reg;
                res_cnt_next = cnt_reg;
                if (op_reg == OP_INSERT)
                begin
                    ram_we               = 1'b1;
                    res_cnt_next         = new_cnt;
                    counts_next[cls_reg] = new_cnt;
                end
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, TAG_W'(0), SCORE_W'(0), res_cnt_reg, res_pos_reg,
                                     res_q_reg};
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RDOUT:
            begin
                ram_raddr = base_reg + ADDR_W'(idx_reg);
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, rd_tag, rd_val, cnt_reg, idx_reg, 1'b1};
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = rd_last;
                    if (rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_raddr = base_reg + ADDR_W'(idx_reg) + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hib_reg      <= 1'b1;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            hib_reg      <= hib_next;
            m_tvalid_reg <= m_tvalid_next;
            counts_reg   <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cls_reg     <= cls_next;
        base_reg    <= base_next;
        val_reg     <= val_next;
        tag_reg     <= tag_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        carry_reg   <= carry_next;
        res_q_reg   <= res_q_next;
        res_pos_reg <= res_pos_next;
        res_cnt_reg <= res_cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
`default_nettype wire

@@ sim/per_class_top_k_table_test.sv @@
// Self-checking testbench for per_class_top_k_table: drives insert, query, readout and
// unused-op items over the stream ports and checks every result against a built-in model.
// Depends on pctk_pkg and per_class_top_k_table.
`default_nettype none
module per_class_top_k_table_test;

    import pctk_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         RUN_LIMIT = 6000000;

    typedef struct packed {
        logic               qualifies;
        idx_t               position;
        idx_t               count;
        logic               holds;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } table_result_t;

    class top_k_book;
        logic [SCORE_W-1:0] vals [NUM_CLASSES][MAX_ENTRIES];
        logic [TAG_W-1:0]   tags [NUM_CLASSES][MAX_ENTRIES];
        int                 counts [NUM_CLASSES];
        bit                 hib;
        table_result_t      due_results[$];
        int                 errors;
        int                 checked;
        int                 listed;

        function new();
            hib = 1'b1;
            errors = 0;
            checked = 0;
            listed = 0;
            foreach (counts[c])
                counts[c] = 0;
        endfunction

        function void queue_result(table_result_t r);
            due_results = {due_results, r};
        endfunction

        function bit beats(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
            return hib ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
        endfunction

        // first slot whose entry the new value strictly beats; ties go behind
        function int rank_of(logic [1:0] cat, logic [SCORE_W-1:0] score);
            int i;
            i = 0;
            while (i < counts[cat] && !beats(score, vals[cat][i]))
                i++;
            return i;
        endfunction

        function void note_item(logic [1:0] op, logic [1:0] cat, logic [SCORE_W-1:0] score,
                                logic [TAG_W-1:0] tag);
            table_result_t r;
            int            n;
            int            slot;
            int            k;
            r = '0;
            n = counts[cat];
            r.count = idx_t'(n);
            r.last = 1'b1;
            case (op) inside
                OP_INSERT, OP_QUERY:
                begin
                    slot = rank_of(cat, score);
                    if (slot >= MAX_ENTRIES)
                    begin
                        r.position = idx_t'(MAX_ENTRIES);
                    end
                    else
                    begin
                        if (op == OP_INSERT)
                        begin
                            for (k = (n < MAX_ENTRIES) ? n : MAX_ENTRIES - 1; k > slot; k--)
                            begin
                                vals[cat][k] = vals[cat][k-1];
                                tags[cat][k] = tags[cat][k-1];
                            end
                            vals[cat][slot] = score;
                            tags[cat][slot] = tag;
                            if (n < MAX_ENTRIES)
                                counts[cat] = n + 1;
                            r.count = idx_t'(counts[cat]);
                        end
                        r.qualifies = 1'b1;
                        r.position = idx_t'(slot);
                    end
                    queue_result(r);
                end
                OP_READOUT:
                begin
                    if (n == 0)
                    begin
                        queue_result(r);
                    end
                    else
                    begin
                        for (k = 0; k < n; k++)
                        begin
                            r.qualifies = 1'b1;
                            r.position = idx_t'(k);
                            r.holds = 1'b1;
                            r.score = vals[cat][k];
                            r.tag = tags[cat][k];
                            r.last = (k == n - 1);
                            queue_result(r);
                        end
                    end
                end
                default:
                begin
                    queue_result(r);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h want %0h", checked, field, got, want));
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (due_results.size() == 0)
            begin
                report("result arrived with nothing expected");
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (want.holds)
                listed++;
            compare("qualifies", 32'(got.qualifies), 32'(want.qualifies));
            compare("position", 32'(got.position), 32'(want.position));
            compare("entry_count", 32'(got.count), 32'(want.count));
            compare("holds_entry", 32'(got.holds), 32'(want.holds));
            compare("out_score", got.score, want.score);
            compare("out_tag", 32'(got.tag), 32'(want.tag));
            compare("last_item", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // category[1:0], score_value[33:2], entry_tag[49:34]
    logic [1:0]  s_tuser = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // qualifies[0], position[4:1], entry_count[8:5],
                                 // out_score[40:9], out_tag[56:41]
    logic        m_tuser;        // holds_entry[0]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b1;

    top_k_book book = new();
    int        items_sent = 0;
    int        order_writes = 0;

    per_class_top_k_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", book.due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, with quiet stretches
    initial
    begin
        table_result_t got;
        int            gap;
        int            taken;
        taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = (((taken / 50) % 3) == 1) ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.qualifies = m_tdata[0];
            got.position  = m_tdata[4:1];
            got.count     = m_tdata[8:5];
            got.holds     = m_tuser;
            got.score     = m_tdata[40:9];
            got.tag       = m_tdata[56:41];
            got.last      = m_tlast;
            book.check_result(got);
            taken++;
        end
    end

    task automatic send_item(logic [1:0] op, logic [1:0] cat, logic [SCORE_W-1:0] score,
                             logic [TAG_W-1:0] tag);
        int gap;
        gap = (((items_sent / 35) % 3) == 1) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, tag, score, cat};
        do @(posedge clk); while (!s_tready);
        book.note_item(op, cat, score, tag);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.due_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_order(logic hib);
        cfg_wdata <= hib;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        book.hib = hib;
        order_writes++;
    endtask

    task automatic random_items(int n);
        logic [1:0]         op;
        logic [SCORE_W-1:0] score;
        int                 sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            op = (sel < 55) ? OP_INSERT : (sel < 75) ? OP_QUERY :
                 (sel < 94) ? OP_READOUT : OP_UNUSED;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                score = $urandom_range(0, 16) - 8;     // dense range: many ties
            else if (sel < 8)
                score = $urandom();
            else if (sel == 8)
                score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                score = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            send_item(op, 2'($urandom_range(0, 3)), score, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_order(1'b1);

        // empty lists, unused op, query on an empty list
        send_item(OP_READOUT, 2'd0, 32'd0, 16'h0000);
        send_item(OP_UNUSED, 2'd1, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_QUERY, 2'd2, 32'd5, 16'h0000);
        // fill class 0 with extremes and ties
        send_item(OP_INSERT, 2'd0, 32'd0, 16'h0000);
        send_item(OP_INSERT, 2'd0, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(OP_INSERT, 2'd0, 32'h8000_0000, 16'h1234);
        send_item(OP_INSERT, 2'd0, 32'd0, 16'h0001);
        send_item(OP_INSERT, 2'd0, 32'hFFFF_FFFF, 16'h00AA);
        send_item(OP_INSERT, 2'd0, 32'd100, 16'h0100);
        send_item(OP_INSERT, 2'd0, 32'd100, 16'h0101);
        send_item(OP_INSERT, 2'd0, -32'sd100, 16'h5555);
        send_item(OP_INSERT, 2'd0, 32'd7, 16'hAAAA);
        send_item(OP_INSERT, 2'd0, 32'd8, 16'h8000);
        // full list: equal to worst is dropped, better evicts the worst
        send_item(OP_INSERT, 2'd0, 32'h8000_0000, 16'h0BAD);
        send_item(OP_QUERY, 2'd0, 32'h8000_0000, 16'h0000);
        send_item(OP_QUERY, 2'd0, 32'h7FFF_FFFF, 16'h0000);
        send_item(OP_QUERY, 2'd0, 32'hFFFF_FFFE, 16'h0000);
        send_item(OP_INSERT, 2'd0, 32'd5, 16'h7FFF);
        send_item(OP_READOUT, 2'd0, 32'd0, 16'h0000);
        send_item(OP_UNUSED, 2'd0, 32'd0, 16'h0000);
        send_item(OP_INSERT, 2'd3, 32'h8000_0000, 16'hFFFF);
        send_item(OP_READOUT, 2'd3, 32'd0, 16'h0000);
        drain();

        random_items(160);
        drain();
        set_order(1'b0);
        send_item(OP_QUERY, 2'd0, 32'h8000_0000, 16'h0000);
        send_item(OP_INSERT, 2'd0, 32'h8000_0000, 16'hC0DE);
        send_item(OP_READOUT, 2'd0, 32'd0, 16'h0000);
        random_items(140);
        drain();
        set_order(1'b1);
        random_items(40);

        s_tvalid <= 1'b0;
        while (book.due_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("sent %0d items over %0d ranking-order writes, covering inserts, queries,",
                 items_sent, order_writes);
        $display("readouts and unused ops; checked %0d results, %0d of them list entries",
                 book.checked, book.listed);
        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
